>>> hdl/pat_pkg.sv
// Shared types and constants for the peer address table.
`default_nettype none

package pat_pkg;

    // Field widths of requests and results
    localparam int ADDR_W  = 48;
    localparam int SLOT_W  = 4;
    localparam int NODE_W  = 5;
    localparam int REQ_W   = 2;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;

    // Result field positions in m_tdata
    localparam int RES_FOUND_LSB  = 0;
    localparam int RES_NODE_LSB   = 1;
    localparam int RES_ADDR_LSB   = 6;
    localparam int RES_ONLINE_LSB = 54;
    localparam int RES_FREE_LSB   = 55;
    localparam int RES_W          = 60;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE  = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    // One result, found in the lowest bit
    typedef struct packed {
        logic [NODE_W-1:0] free_node;
        logic              entry_online;
        logic [ADDR_W-1:0] entry_address;
        logic [NODE_W-1:0] node_number;
        logic              found;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/peer_address_table.sv
// Peer address table: top level with register table, match logic and stream ports.
//
// Usage
//   s_ channel carries one request per transfer: req_type (write slot, delete
//   by address, look up address, read slot), slot and a 48-bit address.
//   m_ channel returns exactly one result per request: found, node_number
//   (matched slot plus one, 0 if none), entry_address and entry_online for
//   reads, and free_node, the first empty slot plus one after the request.
//   The table is TABLE_ENTRIES flip-flop entries compared all at once against
//   the request address, with a priority encoder picking the first match.
// Pipeline and throughput
//   A request is held in an input register, then resolved combinationally
//   into the result register, so m_tvalid rises once the request has passed
//   both registers. One request per cycle is sustained while m_tready holds
//   high; a request sees every table update made by the requests before it.
// Reset
//   aresetn low clears every entry to empty and drops both valid flags.
// Stall
//   While m_tready is low the result holds; the input register still takes
//   one more request, and s_tready falls once both registers are full.
`default_nettype none

module peer_address_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: req_type[1:0], slot[5:2], address[53:6], zero pad [55:54]
    input  wire logic [pat_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // m_tdata: found[0], node_number[5:1], entry_address[53:6],
    //          entry_online[54], free_node[59:55], zero pad [63:60]
    output logic [pat_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // Input stage
    logic                              in_valid_reg, in_valid_next;
    pat_pkg::req_t                     in_req_reg;
    logic [pat_pkg::SLOT_W-1:0]        in_slot_reg;
    logic [pat_pkg::ADDR_W-1:0]        in_addr_reg;

    // Table
    logic [pat_pkg::ADDR_W-1:0]        entry_reg [TABLE_ENTRIES];
    logic [pat_pkg::ADDR_W-1:0]        entry_next [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]          occupied_reg, occupied_next;

    // Result stage
    logic                              m_valid_reg, m_valid_next;
    pat_pkg::result_t                  result_reg, result_next;

    // Match and selection
    logic [TABLE_ENTRIES-1:0]          match_vec;
    logic [TABLE_ENTRIES-1:0]          slot_sel;
    logic                              hit_any;
    logic [IDX_W-1:0]                  hit_idx;
    logic                              free_any;
    logic [IDX_W-1:0]                  free_idx;
    logic [pat_pkg::ADDR_W-1:0]        read_addr;
    logic                              out_ready;
    logic                              fire;
    logic                              s_take;

    // Handshake
    assign out_ready = !m_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_take    = s_tvalid && s_tready;

    assign in_valid_next = s_take || (in_valid_reg && !fire);
    assign m_valid_next  = fire || (m_valid_reg && !m_tready);

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_take) begin
            in_req_reg  <= pat_pkg::req_t'(s_tdata[1:0]);
            in_slot_reg <= s_tdata[5:2];
            in_addr_reg <= s_tdata[53:6];
        end
    end

    // Per-entry compare, slot decode and read mux
    always_comb begin
        read_addr = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match_vec[i] = (entry_reg[i] == in_addr_reg);
            slot_sel[i]  = (32'(in_slot_reg) == i);
            if (slot_sel[i]) begin
                read_addr = read_addr | entry_reg[i];
            end
        end
    end

    pat_first_hit #(
        .N     (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_match_enc (
        .hits    (match_vec),
        .hit_any (hit_any),
        .hit_idx (hit_idx)
    );

    // Table update for the current request
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            entry_next[i]    = entry_reg[i];
            occupied_next[i] = occupied_reg[i];
            unique case (in_req_reg)
                pat_pkg::REQ_WRITE: begin
                    if (slot_sel[i]) begin
                        entry_next[i]    = in_addr_reg;
                        occupied_next[i] = (in_addr_reg != '0);
                    end
                end
                pat_pkg::REQ_DELETE: begin
                    if (hit_any && (hit_idx == IDX_W'(i))) begin
                        entry_next[i]    = '0;
                        occupied_next[i] = 1'b0;
                    end
                end
                pat_pkg::REQ_LOOKUP,
                pat_pkg::REQ_READ: begin
                end
            endcase
        end
    end

    // First free slot after the update
    pat_first_hit #(
        .N     (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_free_enc (
        .hits    (~occupied_next),
        .hit_any (free_any),
        .hit_idx (free_idx)
    );

    // Result fields
    always_comb begin
        result_next               = '0;
        result_next.free_node     = free_any ? pat_pkg::NODE_W'(32'(free_idx) + 1) : '0;
        unique case (in_req_reg)
            pat_pkg::REQ_DELETE,
            pat_pkg::REQ_LOOKUP: begin
                result_next.found       = hit_any;
                result_next.node_number =
                    hit_any ? pat_pkg::NODE_W'(32'(hit_idx) + 1) : '0;
            end
            pat_pkg::REQ_READ: begin
                result_next.entry_address = read_addr;
                result_next.entry_online  = (read_addr != '0);
            end
            pat_pkg::REQ_WRITE: begin
            end
        endcase
    end

    // Table and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            occupied_reg <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                entry_reg[i] <= '0;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            if (fire) begin
                occupied_reg <= occupied_next;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    entry_reg[i] <= entry_next[i];
                end
            end
        end
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(pat_pkg::M_TDATA_W - pat_pkg::RES_W)'(0), result_reg};

endmodule

`default_nettype wire

>>> hdl/pat_first_hit.sv
// Priority encoder: lowest set bit of a hit vector.
`default_nettype none

module pat_first_hit #(
    parameter int N     = 16,
    parameter int IDX_W = 4
) (
    input  wire logic [N-1:0]     hits,
    output logic                  hit_any,
    output logic [IDX_W-1:0]      hit_idx
);

    assign hit_any = |hits;

    // Scan from the top so the lowest set bit wins
    always_comb begin
        hit_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (hits[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/pat_checker.sv
// Port-level checks for the peer address table, bound to the top level.
`default_nettype none

module pat_checker #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [pat_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready
);

    logic                        res_found;
    logic [pat_pkg::NODE_W-1:0]  res_node;
    logic [pat_pkg::ADDR_W-1:0]  res_addr;
    logic                        res_online;
    logic [pat_pkg::NODE_W-1:0]  res_free;

    assign res_found  = m_tdata[pat_pkg::RES_FOUND_LSB];
    assign res_node   = m_tdata[pat_pkg::RES_NODE_LSB +: pat_pkg::NODE_W];
    assign res_addr   = m_tdata[pat_pkg::RES_ADDR_LSB +: pat_pkg::ADDR_W];
    assign res_online = m_tdata[pat_pkg::RES_ONLINE_LSB];
    assign res_free   = m_tdata[pat_pkg::RES_FREE_LSB +: pat_pkg::NODE_W];

    // A node number is given exactly when a match was found
    a_found_node: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (TABLE_ENTRIES <= 31)) |-> (res_found == (res_node != '0)))
        else $error("found and node_number disagree");

    // Online flag follows the read address
    a_online: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_online == (res_addr != '0)))
        else $error("entry_online does not match entry_address");

    // Free node never points past the table
    a_free_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (TABLE_ENTRIES <= 31)) |-> (32'(res_free) <= TABLE_ENTRIES))
        else $error("free_node beyond table size");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

bind peer_address_table pat_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
) u_pat_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
